[rtl/dpp_pkg.sv]
// derivation path parser: shared types and constants
// no dependencies; imported by every module of the block but dpp_acc
package dpp_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_INDEX       = 3'd0,
    ST_DONE        = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_MISPLACED_M = 3'd3,
    ST_BAD_CHAR    = 3'd4,
    ST_NO_DIGITS   = 3'd5,
    ST_RANGE       = 3'd6
  } status_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] child_index;
    status_t     status;
    logic        last;
  } res_t;

  // what one parse step hands to the result queue
  typedef struct packed {
    logic emit0;
    logic emit1;
    res_t r0;
    res_t r1;
  } step_res_t;

  localparam int unsigned RQ_DEPTH = 4;

endpackage

[rtl/derivation_path_parser.sv]
// derivation path parser top level: input register, parse core, result queue
// depends on dpp_pkg, dpp_core, dpp_acc and dpp_rq
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in_     | input     | in_valid / in_stall  | in_op, in_ch
//  out_    | output    | out_valid / out_stall| out_child_index, out_status, out_last
//
// one character transaction per cycle sustained while results keep within one per cycle;
// an item is held in the input register, is parsed there by the core and its
// results land in the result queue, so a result reaches out_ through the input
// register and then the result queue and is taken while out_stall is low
// the end-of-path item can give two results; the queue drains one per cycle while out_stall is low
// reset (rst_n low, synchronous) empties the pipeline and clears the parse state
// out_stall backs up the queue; once it holds more than two results an item in the
// input register is held there and in_stall rises
module derivation_path_parser
  import dpp_pkg::*;
#(
  parameter int LONG_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_child_index,
  output logic [2:0]  out_status,
  output logic        out_last
);

  // input register
  logic       in_valid_r;
  logic       op_r;
  logic [7:0] ch_r;

  logic      step;
  logic      room;
  step_res_t step_res;
  res_t      head;

  // the parse step fires when an item sits in the input register and the
  // queue can take both results of an end-of-path item
  assign step     = in_valid_r & room;
  assign in_stall = in_valid_r & ~room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r <= in_op;
      ch_r <= in_ch;
    end
  end

  dpp_core #(.LONG_BITS(LONG_BITS)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .op    (op_r),
    .ch    (ch_r),
    .res   (step_res)
  );

  dpp_rq #(.DEPTH(RQ_DEPTH)) u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push0    (step & step_res.emit0),
    .push1    (step & step_res.emit1),
    .wr       (step_res),
    .room     (room),
    .rd_valid (out_valid),
    .rd_pop   (~out_stall),
    .rd_data  (head)
  );

  assign out_child_index = head.child_index;
  assign out_status      = head.status;
  assign out_last        = head.last;

endmodule

[rtl/dpp_acc.sv]
// derivation path parser: saturating digit accumulator (value * base + digit)
// no package dependency; used by dpp_core for the hex and decimal values
module dpp_acc #(
  parameter int VAL_W      = 63,
  parameter bit IS_DECIMAL = 1'b0
) (
  input  logic [VAL_W-1:0] v_in,
  input  logic             big_in,
  input  logic [3:0]       digit,
  output logic [VAL_W-1:0] v_out,
  output logic             big_out
);

  localparam int EXT_W = VAL_W + 4;

  logic [EXT_W-1:0] v_ext;
  logic [EXT_W-1:0] scaled;
  logic [EXT_W-1:0] sum;
  logic             ovf;

  assign v_ext = EXT_W'(v_in);

  // times ten as 8v + 2v, times sixteen as a plain shift
  assign scaled = IS_DECIMAL ? ((v_ext << 3) + (v_ext << 1)) : (v_ext << 4);
  assign sum    = scaled + EXT_W'(digit);

  // anything above the value field is past the signed long range
  assign ovf     = (sum[EXT_W-1:VAL_W] != '0);
  assign big_out = big_in | ovf;
  assign v_out   = (big_in | ovf) ? v_in : sum[VAL_W-1:0];

endmodule

[rtl/dpp_core.sv]
// derivation path parser: parse state and per-character step logic
// depends on dpp_pkg and dpp_acc
module dpp_core
  import dpp_pkg::*;
#(
  parameter int LONG_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      op,
  input  logic [7:0] ch,
  output step_res_t res
);

  localparam int VAL_W = LONG_BITS - 1;

  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_APOS  = 8'h27;
  localparam logic [7:0]  CH_LX    = 8'h78;
  localparam logic [7:0]  CH_UX    = 8'h58;
  localparam logic [7:0]  CH_M     = 8'h6D;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [31:0] HARD_MASK = 32'h8000_0000;

  logic [VAL_W-1:0] hex_val_r, hex_val_nxt, dec_val_r, dec_val_nxt;
  logic hex_big_r, hex_big_nxt, dec_big_r, dec_big_nxt;
  logic dec_has_r, dec_has_nxt, dec_closed_r, dec_closed_nxt;
  logic seg_nonempty_r, seg_nonempty_nxt, hard_r, hard_nxt;
  logic hex_mode_r, hex_mode_nxt, prev_zero_r, prev_zero_nxt;
  logic seen_sep_r, seen_sep_nxt, past_first_r, past_first_nxt;
  logic err_hold_r, err_hold_nxt;

  logic             is_dec, is_lhex, is_uhex;
  logic [3:0]       digit;
  logic [VAL_W-1:0] hex_acc_v, dec_acc_v, close_val;
  logic             hex_acc_big, dec_acc_big;
  logic             close_emit;
  status_t          close_stat;
  logic [31:0]      close_idx;

  // character classes
  always_comb begin
    is_dec  = (ch >= 8'h30) && (ch <= 8'h39);
    is_lhex = (ch >= 8'h61) && (ch <= 8'h66);
    is_uhex = (ch >= 8'h41) && (ch <= 8'h46);
    if (is_dec) begin
      digit = 4'(ch - 8'h30);
    end else if (is_lhex) begin
      digit = 4'(ch - 8'h57);
    end else if (is_uhex) begin
      digit = 4'(ch - 8'h37);
    end else begin
      digit = 4'd0;
    end
  end

  dpp_acc #(.VAL_W(VAL_W), .IS_DECIMAL(1'b0)) u_hex_acc (
    .v_in    (hex_val_r),
    .big_in  (hex_big_r),
    .digit   (digit),
    .v_out   (hex_acc_v),
    .big_out (hex_acc_big)
  );

  dpp_acc #(.VAL_W(VAL_W), .IS_DECIMAL(1'b1)) u_dec_acc (
    .v_in    (dec_val_r),
    .big_in  (dec_big_r),
    .digit   (digit),
    .v_out   (dec_acc_v),
    .big_out (dec_acc_big)
  );

  // outcome of closing the current segment
  always_comb begin
    close_emit = seg_nonempty_r | seen_sep_r;
    close_val  = hex_mode_r ? hex_val_r : dec_val_r;
    if (!seg_nonempty_r) begin
      close_stat = ST_EMPTY;
    end else if (hex_mode_r) begin
      close_stat = hex_big_r ? ST_RANGE : ST_INDEX;
    end else if (!dec_has_r) begin
      close_stat = ST_NO_DIGITS;
    end else begin
      close_stat = dec_big_r ? ST_RANGE : ST_INDEX;
    end
    if (close_stat == ST_INDEX) begin
      close_idx = 32'(close_val) | (hard_r ? HARD_MASK : 32'd0);
    end else begin
      close_idx = 32'd0;
    end
  end

  always_comb begin
    hex_val_nxt      = hex_val_r;
    hex_big_nxt      = hex_big_r;
    dec_val_nxt      = dec_val_r;
    dec_big_nxt      = dec_big_r;
    dec_has_nxt      = dec_has_r;
    dec_closed_nxt   = dec_closed_r;
    seg_nonempty_nxt = seg_nonempty_r;
    hard_nxt         = hard_r;
    hex_mode_nxt     = hex_mode_r;
    prev_zero_nxt    = prev_zero_r;
    seen_sep_nxt     = seen_sep_r;
    past_first_nxt   = past_first_r;
    err_hold_nxt     = err_hold_r;
    res              = '0;
    res.r0.status    = ST_INDEX;
    res.r1.status    = ST_DONE;
    res.r1.last      = 1'b1;

    if (op) begin
      if (!err_hold_r) begin
        res.emit0 = 1'b1;
        if (!close_emit) begin
          res.r0.status = ST_DONE;
          res.r0.last   = 1'b1;
        end else if (close_stat == ST_INDEX) begin
          res.r0.child_index = close_idx;
          res.emit1          = 1'b1;
        end else begin
          res.r0.status = close_stat;
          res.r0.last   = 1'b1;
        end
      end
      // end of path returns everything to reset
      hex_val_nxt      = '0;
      hex_big_nxt      = 1'b0;
      dec_val_nxt      = '0;
      dec_big_nxt      = 1'b0;
      dec_has_nxt      = 1'b0;
      dec_closed_nxt   = 1'b0;
      seg_nonempty_nxt = 1'b0;
      hard_nxt         = 1'b0;
      hex_mode_nxt     = 1'b0;
      prev_zero_nxt    = 1'b0;
      seen_sep_nxt     = 1'b0;
      past_first_nxt   = 1'b0;
      err_hold_nxt     = 1'b0;
    end else if (!err_hold_r) begin
      past_first_nxt = 1'b1;
      if (ch == CH_SLASH) begin
        if (close_emit) begin
          res.emit0          = 1'b1;
          res.r0.child_index = close_idx;
          res.r0.status      = close_stat;
          res.r0.last        = (close_stat != ST_INDEX);
          err_hold_nxt       = (close_stat != ST_INDEX);
        end
        hex_val_nxt      = '0;
        hex_big_nxt      = 1'b0;
        dec_val_nxt      = '0;
        dec_big_nxt      = 1'b0;
        dec_has_nxt      = 1'b0;
        dec_closed_nxt   = 1'b0;
        seg_nonempty_nxt = 1'b0;
        hard_nxt         = 1'b0;
        hex_mode_nxt     = 1'b0;
        seen_sep_nxt     = 1'b1;
      end else if (ch == CH_APOS) begin
        hard_nxt = 1'b1;
      end else if (prev_zero_r && ((ch == CH_LX) || (ch == CH_UX))) begin
        hex_mode_nxt  = 1'b1;
        prev_zero_nxt = 1'b0;
      end else if (ch == CH_M) begin
        if (past_first_r) begin
          res.emit0     = 1'b1;
          res.r0.status = ST_MISPLACED_M;
          res.r0.last   = 1'b1;
          err_hold_nxt  = 1'b1;
        end
      end else if (is_dec || is_lhex || is_uhex) begin
        seg_nonempty_nxt = 1'b1;
        hex_val_nxt      = hex_acc_v;
        hex_big_nxt      = hex_acc_big;
        if (!is_dec) begin
          dec_closed_nxt = 1'b1;
        end else if (!dec_closed_r) begin
          dec_has_nxt = 1'b1;
          dec_val_nxt = dec_acc_v;
          dec_big_nxt = dec_acc_big;
        end
        prev_zero_nxt = (ch == CH_ZERO);
      end else begin
        res.emit0     = 1'b1;
        res.r0.status = ST_BAD_CHAR;
        res.r0.last   = 1'b1;
        err_hold_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_val_r      <= '0;
      hex_big_r      <= 1'b0;
      dec_val_r      <= '0;
      dec_big_r      <= 1'b0;
      dec_has_r      <= 1'b0;
      dec_closed_r   <= 1'b0;
      seg_nonempty_r <= 1'b0;
      hard_r         <= 1'b0;
      hex_mode_r     <= 1'b0;
      prev_zero_r    <= 1'b0;
      seen_sep_r     <= 1'b0;
      past_first_r   <= 1'b0;
      err_hold_r     <= 1'b0;
    end else if (step) begin
      hex_val_r      <= hex_val_nxt;
      hex_big_r      <= hex_big_nxt;
      dec_val_r      <= dec_val_nxt;
      dec_big_r      <= dec_big_nxt;
      dec_has_r      <= dec_has_nxt;
      dec_closed_r   <= dec_closed_nxt;
      seg_nonempty_r <= seg_nonempty_nxt;
      hard_r         <= hard_nxt;
      hex_mode_r     <= hex_mode_nxt;
      prev_zero_r    <= prev_zero_nxt;
      seen_sep_r     <= seen_sep_nxt;
      past_first_r   <= past_first_nxt;
      err_hold_r     <= err_hold_nxt;
    end
  end

endmodule

[rtl/dpp_rq.sv]
// derivation path parser: result queue, up to two writes and one read a cycle
// depends on dpp_pkg
module dpp_rq
  import dpp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push0,
  input  logic      push1,
  input  step_res_t wr,
  output logic      room,
  output logic      rd_valid,
  input  logic      rd_pop,
  output res_t      rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign pop      = rd_valid & rd_pop;
  // room for the worst case of two results from one item
  assign room     = (cnt_r <= CNT_W'(DEPTH - 2));
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push0 && push1) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end else if (push0) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push0) + CNT_W'(push0 & push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= wr.r0;
    end
    if (push0 && push1) begin
      mem_r[wr_ptr_p1] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/dpp_checker.sv]
// derivation path parser: port-level checker and its bind to the top level
// depends on dpp_pkg
module dpp_checker
  import dpp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_child_index,
  input logic [2:0]  out_status,
  input logic        out_last
);

  // only an index result carries a value
  a_zero_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_INDEX) |-> out_child_index == 32'd0)
    else $error("non-index result with a child index");

  // index results never close a path, every other status does
  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_status != ST_INDEX)))
    else $error("last flag disagrees with status");

  // nothing comes out in the cycle after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_child_index)
      && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // the input only backs up behind waiting results
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind derivation_path_parser dpp_checker u_dpp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_child_index (out_child_index),
  .out_status      (out_status),
  .out_last        (out_last)
);
